@@ rtl/core/symbol_interning_table_defines.svh @@
// assertion macros for the symbol interning table
// used by symbol_interning_table.sv, expects clk and rst_n in scope
`ifndef SYMBOL_INTERNING_TABLE_DEFINES_SVH
`define SYMBOL_INTERNING_TABLE_DEFINES_SVH

// checked only out of reset
`define SIT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SIT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/sit_pkg.sv @@
// types and constants for the symbol interning table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

    localparam int SYM_W        = 8;
    localparam int SYM_COUNT    = 1 << SYM_W;
    localparam int STATUS_W     = 2;
    localparam int INDEX_W      = 8;
    localparam int COUNT_OUT_W  = 9;
    localparam int TABLE_DEPTH_DEF = 256;

    typedef enum logic [0:0] {
        OP_INTERN  = 1'b0,
        OP_REVERSE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 2'd0,
        ST_ADDED     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

endpackage

`default_nettype wire

@@ rtl/core/symbol_interning_table.sv @@
// symbol interning table: byte symbols to dense indices, and back
// depends on sit_pkg and symbol_interning_table_defines.svh
//
// Takes one item per cycle while the output is not stalled and returns one result per item.
// An item is registered at its accepting edge together with synchronous reads of the forward
// table (256 entries, indexed by symbol) and the reverse store (TABLE_DEPTH entries, indexed
// by position). When the first stage advances, a single pass resolves the request, appends a
// new symbol with one write to each memory, and loads the result register. A stalled result
// holds the next item in the first stage and that stalls the input; the output stall alone
// sets the rate. A one-entry bypass of the last append covers the read taken at the same
// edge as that write. The forward table carries one valid flop per entry, cleared at reset;
// the reverse store is not cleared, so no clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "symbol_interning_table_defines.svh"

module symbol_interning_table #(
    parameter int TABLE_DEPTH = sit_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            opcode,
    input  wire logic [sit_pkg::SYM_W-1:0]       symbol,
    input  wire logic [sit_pkg::INDEX_W-1:0]     lookup_index,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [sit_pkg::STATUS_W-1:0]         status,
    output logic [sit_pkg::INDEX_W-1:0]          index_out,
    output logic [sit_pkg::SYM_W-1:0]            symbol_out,
    output logic [sit_pkg::COUNT_OUT_W-1:0]      symbol_count
);

    import sit_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // storage
    logic [AW-1:0]        fwd_mem [SYM_COUNT];
    logic [SYM_W-1:0]     rev_mem [TABLE_DEPTH];
    logic [SYM_COUNT-1:0] fwd_valid_reg;
    logic [CW-1:0]        count_reg;

    // stage one
    logic                 s1_valid_reg;
    logic                 s1_op_reg;
    logic [SYM_W-1:0]     s1_sym_reg;
    logic [INDEX_W-1:0]   s1_idx_reg;
    logic [AW-1:0]        fwd_rd_reg;
    logic [SYM_W-1:0]     rev_rd_reg;

    // last append
    logic                 byp_valid_reg;
    logic [SYM_W-1:0]     byp_sym_reg;
    logic [AW-1:0]        byp_slot_reg;

    // result
    logic                 out_valid_reg;
    status_t              status_reg;
    logic [INDEX_W-1:0]   index_reg;
    logic [SYM_W-1:0]     sym_out_reg;
    logic [CW-1:0]        count_out_reg;

    logic                 in_fire;
    logic                 s1_adv;
    logic                 present;
    logic                 full;
    logic                 add;
    logic [AW-1:0]        slot;
    logic [AW-1:0]        fwd_idx;
    logic [SYM_W-1:0]     rev_sym;
    status_t              status_next;
    logic [INDEX_W-1:0]   index_next;
    logic [SYM_W-1:0]     sym_out_next;
    logic [CW-1:0]        count_next;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_fire  = in_valid && !in_stall;

    assign slot    = count_reg[AW-1:0];
    assign full    = (count_reg == CW'(TABLE_DEPTH));
    assign present = fwd_valid_reg[s1_sym_reg];
    assign fwd_idx = (byp_valid_reg && byp_sym_reg == s1_sym_reg) ? byp_slot_reg : fwd_rd_reg;
    assign rev_sym = (byp_valid_reg && byp_slot_reg == s1_idx_reg[AW-1:0])
                     ? byp_sym_reg : rev_rd_reg;
    assign add     = (s1_op_reg == OP_INTERN) && !present && !full;

    always_comb
    begin
        status_next  = ST_FOUND;
        index_next   = '0;
        sym_out_next = '0;
        count_next   = count_reg;
        if (s1_op_reg == OP_INTERN)
        begin
            if (present)
            begin
                index_next = INDEX_W'(fwd_idx);
            end
            else if (!full)
            begin
                status_next = ST_ADDED;
                index_next  = INDEX_W'(slot);
                count_next  = count_reg + CW'(1);
            end
            else
            begin
                status_next = ST_FULL;
            end
        end
        else
        begin
            if (COUNT_OUT_W'(s1_idx_reg) < COUNT_OUT_W'(count_reg))
            begin
                index_next   = s1_idx_reg;
                sym_out_next = rev_sym;
            end
            else
            begin
                status_next = ST_NOT_FOUND;
            end
        end
    end

    // memories: registered read on accept, write on append
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fwd_rd_reg <= fwd_mem[symbol];
            rev_rd_reg <= rev_mem[lookup_index[AW-1:0]];
        end
        if (s1_adv && add)
        begin
            fwd_mem[s1_sym_reg] <= slot;
            rev_mem[slot]       <= s1_sym_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byp_valid_reg <= 1'b0;
            fwd_valid_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                byp_valid_reg <= add;
                count_reg     <= count_next;
                if (add)
                begin
                    fwd_valid_reg[s1_sym_reg] <= 1'b1;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg  <= opcode;
            s1_sym_reg <= symbol;
            s1_idx_reg <= lookup_index;
        end
        if (s1_adv)
        begin
            byp_sym_reg   <= s1_sym_reg;
            byp_slot_reg  <= slot;
            status_reg    <= status_next;
            index_reg     <= index_next;
            sym_out_reg   <= sym_out_next;
            count_out_reg <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign index_out    = index_reg;
    assign symbol_out   = sym_out_reg;
    assign symbol_count = COUNT_OUT_W'(count_out_reg);

    `SIT_ASSERT(a_count_bound, count_reg <= CW'(TABLE_DEPTH), "count above depth")
    `SIT_ASSERT(a_append_grows,
        (s1_adv && add) |=> count_reg == $past(count_reg) + CW'(1),
        "append did not grow count")
    `SIT_ASSERT(a_added_index,
        (out_valid_reg && status_reg == ST_ADDED)
            |-> (COUNT_OUT_W'(index_reg) + COUNT_OUT_W'(1) == COUNT_OUT_W'(count_out_reg)),
        "added index not last")
    `SIT_ASSERT(a_full_only_at_depth,
        (out_valid_reg && status_reg == ST_FULL) |-> count_out_reg == CW'(TABLE_DEPTH),
        "full reported below depth")
    `SIT_ASSERT_ALWAYS(a_reset_clears,
        !rst_n |=> (count_reg == '0 && fwd_valid_reg == '0),
        "reset left table state")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for symbol_interning_table: directed rows, then random items
// under random valid and stall, with results compared against an in-bench predictor
// depends on sit_pkg and symbol_interning_table
`timescale 1ns / 1ps

module tb;

    import sit_pkg::*;

    localparam int DEPTH         = 256;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT_ITEM  = 300;
    localparam int DRAIN_AT_ITEM = 650;
    localparam int IDLE_LIMIT    = 5000;
    localparam int TAIL_CYCLES   = 20;
    localparam int PRINT_CAP     = 200;

    typedef struct packed {
        status_t                 status;
        logic [INDEX_W-1:0]      index;
        logic [SYM_W-1:0]        sym;
        logic [COUNT_OUT_W-1:0]  count;
    } result_t;

    typedef struct {
        op_t                 op;
        logic [SYM_W-1:0]    sym;
        logic [INDEX_W-1:0]  idx;
        bit                  typed;
        result_t             res;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    opcode = 1'b0;
    logic [SYM_W-1:0]        symbol = '0;
    logic [INDEX_W-1:0]      lookup_index = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic [INDEX_W-1:0]      index_out;
    logic [SYM_W-1:0]        symbol_out;
    logic [COUNT_OUT_W-1:0]  symbol_count;

    bit                      sym_known [SYM_COUNT];
    logic [INDEX_W-1:0]      sym_index [SYM_COUNT];
    logic [SYM_W-1:0]        index_sym [DEPTH];
    int unsigned             interned_count;

    result_t                 pending_results [$];
    int unsigned             mismatches;
    int unsigned             idle_cycles;
    bit                      long_hold_req;

    symbol_interning_table #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .symbol       (symbol),
        .lookup_index (lookup_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .index_out    (index_out),
        .symbol_out   (symbol_out),
        .symbol_count (symbol_count)
    );

    always #5 clk = ~clk;

    function automatic result_t resolve_request(op_t op, logic [SYM_W-1:0] sym,
                                                logic [INDEX_W-1:0] idx);
        result_t r;
        r = '{status: ST_FOUND, index: '0, sym: '0, count: '0};
        if (op == OP_INTERN)
        begin
            if (sym_known[sym])
            begin
                r.index = sym_index[sym];
            end
            else if (interned_count < DEPTH)
            begin
                sym_known[sym] = 1'b1;
                sym_index[sym] = interned_count[INDEX_W-1:0];
                index_sym[interned_count] = sym;
                r.status = ST_ADDED;
                r.index = interned_count[INDEX_W-1:0];
                interned_count++;
            end
            else
            begin
                r.status = ST_FULL;
            end
        end
        else
        begin
            if (idx < interned_count)
            begin
                r.index = idx;
                r.sym = index_sym[idx];
            end
            else
            begin
                r.status = ST_NOT_FOUND;
            end
        end
        r.count = interned_count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic logic [SYM_W-1:0] pick_unseen_symbol();
        int unsigned start;
        logic [SYM_W-1:0] s;
        start = $urandom_range(0, SYM_COUNT - 1);
        for (int i = 0; i < SYM_COUNT; i++)
        begin
            s = SYM_W'((start + i) % SYM_COUNT);
            if (!sym_known[s])
                return s;
        end
        return start[SYM_W-1:0];
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic offer_item(op_t op, logic [SYM_W-1:0] sym, logic [INDEX_W-1:0] idx,
                              bit typed, result_t typed_res);
        result_t predicted;
        in_valid <= 1'b1;
        opcode <= op;
        symbol <= sym;
        lookup_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = resolve_request(op, sym, idx);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic offer_random_item();
        result_t unused;
        logic [SYM_W-1:0] sym;
        logic [INDEX_W-1:0] idx;
        unused = '0;
        sym = SYM_W'($urandom);
        idx = INDEX_W'($urandom);
        if ($urandom_range(0, 99) < 55)
        begin
            if ($urandom_range(0, 2) == 0)
                sym = pick_unseen_symbol();
            offer_item(OP_INTERN, sym, idx, 1'b0, unused);
        end
        else
        begin
            if (interned_count > 0 && $urandom_range(0, 9) < 7)
                idx = INDEX_W'($urandom_range(0, interned_count - 1));
            offer_item(OP_REVERSE, sym, idx, 1'b0, unused);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing pending, status", status, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (index_out !== want.index)
                    report_mismatch("index_out", index_out, want.index);
                if (symbol_out !== want.sym)
                    report_mismatch("symbol_out", symbol_out, want.sym);
                if (symbol_count !== want.count)
                    report_mismatch("symbol_count", symbol_count, want.count);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int unsigned mode;
        int unsigned span;
        int unsigned period;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            period = $urandom_range(2, 7);
            for (int i = 0; i < span; i++)
            begin
                @(posedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    2: out_stall <= (i % period == 0);
                    default: out_stall <= ($urandom_range(0, 99) < 70);
                endcase
            end
        end
    end

    initial
    begin
        stim_row_t rows [$];
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        bit drain_now;

        rows = '{
            '{OP_REVERSE, 8'h00, 8'h00, 1, '{ST_NOT_FOUND, 8'd0, 8'h00, 9'd0}},
            '{OP_REVERSE, 8'hFF, 8'hFF, 1, '{ST_NOT_FOUND, 8'd0, 8'h00, 9'd0}},
            '{OP_INTERN,  8'h00, 8'hFF, 1, '{ST_ADDED,     8'd0, 8'h00, 9'd1}},
            '{OP_INTERN,  8'h00, 8'h00, 1, '{ST_FOUND,     8'd0, 8'h00, 9'd1}},
            '{OP_INTERN,  8'hFF, 8'h00, 1, '{ST_ADDED,     8'd1, 8'h00, 9'd2}},
            '{OP_REVERSE, 8'h00, 8'h01, 1, '{ST_FOUND,     8'd1, 8'hFF, 9'd2}},
            '{OP_REVERSE, 8'hFF, 8'h02, 1, '{ST_NOT_FOUND, 8'd0, 8'h00, 9'd2}},
            '{OP_INTERN,  8'hAA, 8'h55, 1, '{ST_ADDED,     8'd2, 8'h00, 9'd3}},
            '{OP_REVERSE, 8'h55, 8'h02, 1, '{ST_FOUND,     8'd2, 8'hAA, 9'd3}},
            '{OP_INTERN,  8'h55, 8'hAA, 1, '{ST_ADDED,     8'd3, 8'h00, 9'd4}},
            '{OP_INTERN,  8'h55, 8'h03, 1, '{ST_FOUND,     8'd3, 8'h00, 9'd4}},
            '{OP_REVERSE, 8'hAA, 8'h00, 1, '{ST_FOUND,     8'd0, 8'h00, 9'd4}},
            '{OP_INTERN,  8'hFF, 8'hFF, 1, '{ST_FOUND,     8'd1, 8'h00, 9'd4}},
            '{OP_REVERSE, 8'h00, 8'h03, 1, '{ST_FOUND,     8'd3, 8'h55, 9'd4}},
            '{OP_REVERSE, 8'h00, 8'h04, 1, '{ST_NOT_FOUND, 8'd0, 8'h00, 9'd4}},
            '{OP_INTERN,  8'h80, 8'h7F, 1, '{ST_ADDED,     8'd4, 8'h00, 9'd5}},
            '{OP_INTERN,  8'h01, 8'h80, 1, '{ST_ADDED,     8'd5, 8'h00, 9'd6}},
            '{OP_REVERSE, 8'h7F, 8'h05, 1, '{ST_FOUND,     8'd5, 8'h01, 9'd6}},
            '{OP_REVERSE, 8'h00, 8'h80, 1, '{ST_NOT_FOUND, 8'd0, 8'h00, 9'd6}},
            '{OP_INTERN,  8'h7F, 8'h00, 0, '0},
            '{OP_REVERSE, 8'h00, 8'h06, 0, '0},
            '{OP_INTERN,  8'h80, 8'h06, 0, '0}
        };

        interned_count = 0;
        mismatches = 0;
        idle_cycles = 0;
        long_hold_req = 1'b0;
        for (int i = 0; i < SYM_COUNT; i++)
        begin
            sym_known[i] = 1'b0;
            sym_index[i] = '0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            offer_item(rows[i].op, rows[i].sym, rows[i].idx, rows[i].typed, rows[i].res);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: burst = $urandom_range(60, 150);
                1: burst = $urandom_range(1, 4);
                default: burst = $urandom_range(1, 40);
            endcase
            drain_now = 1'b0;
            for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++)
            begin
                offer_random_item();
                sent++;
                if (sent == HOLD_AT_ITEM)
                    long_hold_req = 1'b1;
                if (sent == DRAIN_AT_ITEM)
                    drain_now = 1'b1;
            end
            in_valid <= 1'b0;
            @(posedge clk);
            if (drain_now)
            begin
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            else
            begin
                gap = $urandom_range(1, 8);
                repeat (gap - 1) @(posedge clk);
            end
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
